### design/mrrs_pkg.sv
package mrrs_pkg;

   localparam int PRIO_W = 8;

   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_RUN    = 2'd1;
   localparam logic [1:0] FUNC_SLEEP  = 2'd2;
   localparam logic [1:0] FUNC_SWITCH = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [1:0] STATUS_LIST_FULL = 2'd2;
   localparam logic [1:0] STATUS_NO_OTHER  = 2'd3;

   localparam logic [1:0] SLOT_FREE   = 2'd0;
   localparam logic [1:0] SLOT_ALLOC  = 2'd1;
   localparam logic [1:0] SLOT_ACTIVE = 2'd2;

   typedef struct packed {
      logic [1:0]        func;
      logic [5:0]        task_id;
      logic signed [3:0] level;
      logic [7:0]        priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] result_task;
      logic       jump;
      logic [7:0] slice_ticks;
      logic       slice_valid;
      logic [3:0] current_level;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC,
      S_RUN,
      S_SLEEP,
      S_SLEEP_END,
      S_RM_SRCH,
      S_RM_CMP,
      S_RM_FIN,
      S_ADD,
      S_SWITCH,
      S_SW_RD,
      S_SW_NEW,
      S_SW_SLICE,
      S_CUR_RD,
      S_CUR_DN,
      S_OUT
   } fsm_type;

endpackage

### design/mrrs_ram.sv
module mrrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### design/multilevel_round_robin_scheduler.sv
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | mrrs_pkg::req_type
// rsp     | out       | rsp_valid/rsp_stall | mrrs_pkg::rsp_type
//
// One item at a time. alloc scans the slot memory one slot per cycle
// until it finds a free slot. run and sleep, when they unlink a task from
// a list of n entries, search it and then compact it, reading n list
// memory entries in all, one per cycle. The result sits in an output
// register; the next item is taken once it is loaded there, so a result
// stalled on rsp holds the following one and req.
// Reset is synchronous and needs no clearing pass.
module multilevel_round_robin_scheduler #(
   parameter int NUM_TASKS  = 64,
   parameter int NUM_LEVELS = 8,
   parameter int PER_LEVEL  = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mrrs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mrrs_pkg::rsp_type rsp_payload
);

   import mrrs_pkg::*;

   localparam int TIW  = $clog2(NUM_TASKS);
   localparam int LW   = $clog2(NUM_LEVELS);
   localparam int SLW  = LW + 1;
   localparam int CW   = $clog2(PER_LEVEL + 1);
   localparam int PW   = $clog2(PER_LEVEL);
   localparam int PW1  = PW + 1;
   localparam int LD   = NUM_LEVELS * PER_LEVEL;
   localparam int AW   = $clog2(LD);
   localparam int TOTW = $clog2(LD + 1);
   localparam int SW   = 2 + PRIO_W + LW;
   localparam logic [AW-1:0] L1ADDR = AW'((NUM_LEVELS - 1) * PER_LEVEL);

   function automatic logic [AW-1:0] lst_addr(input logic [LW-1:0] l,
                                               input logic [PW-1:0] i);
      return AW'(l) * AW'(PER_LEVEL) + AW'(i);
   endfunction

   fsm_type state_ff, state_in;

   logic [TIW-1:0]   tid_ff, tid_in;
   logic             oor_ff, oor_in;
   logic [3:0]       lraw_ff, lraw_in;
   logic [7:0]       prq_ff, prq_in;
   logic [7:0]       npr_ff, npr_in;
   logic [LW-1:0]    lv_ff, lv_in;
   logic [TIW-1:0]   idx_ff, idx_in;
   logic [PW-1:0]    li_ff, li_in;
   logic [LW-1:0]    rlv_ff, rlv_in;
   logic [CW-1:0]    rn_ff, rn_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic             ret_sleep_ff, ret_sleep_in;
   logic             curhit_ff, curhit_in;
   logic [TIW-1:0]   old_ff, old_in;
   logic             oldok_ff, oldok_in;

   logic [CW-1:0]    cnt_ff [NUM_LEVELS];
   logic [CW-1:0]    cnt_in [NUM_LEVELS];
   logic [PW-1:0]    cur_ff [NUM_LEVELS];
   logic [PW-1:0]    cur_in [NUM_LEVELS];
   logic [SLW-1:0]   srv_ff, srv_in;
   logic             mark_ff, mark_in;
   logic [TOTW-1:0]  tot_ff, tot_in;
   logic [NUM_TASKS-1:0] vld_ff;
   logic             w0_ff, w1_ff;

   logic [1:0]       r_st_ff, r_st_in;
   logic [TIW-1:0]   r_task_ff, r_task_in;
   logic             r_jmp_ff, r_jmp_in;
   logic [7:0]       r_slc_ff, r_slc_in;
   logic             r_slv_ff, r_slv_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             s_we;
   logic [TIW-1:0]   s_waddr, s_raddr, sq_ff;
   logic [SW-1:0]    s_wdata, s_rdata, s_word;
   logic [1:0]       s_st;
   logic [7:0]       s_pr;
   logic [LW-1:0]    s_lv;

   logic             l_we;
   logic [AW-1:0]    l_waddr, l_raddr, lq_ff;
   logic [TIW-1:0]   l_wdata, l_rdata, l_data;

   logic             srv_ok;
   logic [LW-1:0]    srv_idx;
   logic [AW-1:0]    cur_addr;
   logic [SLW-1:0]   rs_lvl;
   logic             accept;
   logic [TIW+5:0]   tid_ext;
   logic [TIW+5:0]   task_ext;
   logic [SLW+3:0]   lvl_ext;

   mrrs_ram #(.WIDTH(SW), .DEPTH(NUM_TASKS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   mrrs_ram #(.WIDTH(TIW), .DEPTH(LD)) u_list_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_addr (l_raddr),
      .rd_data (l_rdata)
   );

   // slots never written read as their reset contents
   always_comb begin
      if (vld_ff[sq_ff]) begin
         s_word = s_rdata;
      end else if (sq_ff == TIW'(0)) begin
         s_word = {SLOT_ACTIVE, 8'd2, LW'(0)};
      end else if (sq_ff == TIW'(1)) begin
         s_word = {SLOT_ACTIVE, 8'd1, LW'(NUM_LEVELS - 1)};
      end else begin
         s_word = '0;
      end
   end
   assign s_st = s_word[SW-1 -: 2];
   assign s_pr = s_word[LW +: PRIO_W];
   assign s_lv = s_word[LW-1:0];

   always_comb begin
      if (lq_ff == AW'(0) && !w0_ff) begin
         l_data = TIW'(0);
      end else if (lq_ff == L1ADDR && !w1_ff) begin
         l_data = TIW'(1);
      end else begin
         l_data = l_rdata;
      end
   end

   assign srv_ok   = srv_ff < SLW'(NUM_LEVELS);
   assign srv_idx  = srv_ok ? srv_ff[LW-1:0] : '0;
   assign cur_addr = lst_addr(srv_idx, cur_ff[srv_idx]);

   always_comb begin
      rs_lvl = SLW'(NUM_LEVELS);
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            rs_lvl = SLW'(i);
         end
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign tid_ext   = {{TIW{1'b0}}, req_payload.task_id};

   always_comb begin
      logic [LW-1:0]  lv;
      logic           need_add;
      logic           hit;
      logic           rm_go;
      logic [LW-1:0]  rm_lvl;
      logic [PW1-1:0] nxt;
      logic [CW-1:0]  nn;
      logic [PW-1:0]  c;
      logic [CW-1:0]  n;

      state_in     = state_ff;
      tid_in       = tid_ff;
      oor_in       = oor_ff;
      lraw_in      = lraw_ff;
      prq_in       = prq_ff;
      npr_in       = npr_ff;
      lv_in        = lv_ff;
      idx_in       = idx_ff;
      li_in        = li_ff;
      rlv_in       = rlv_ff;
      rn_in        = rn_ff;
      pos_in       = pos_ff;
      ret_sleep_in = ret_sleep_ff;
      curhit_in    = curhit_ff;
      old_in       = old_ff;
      oldok_in     = oldok_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      srv_in       = srv_ff;
      mark_in      = mark_ff;
      tot_in       = tot_ff;
      r_st_in      = r_st_ff;
      r_task_in    = r_task_ff;
      r_jmp_in     = r_jmp_ff;
      r_slc_in     = r_slc_ff;
      r_slv_in     = r_slv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      s_we    = 1'b0;
      s_waddr = tid_ff;
      s_wdata = '0;
      s_raddr = tid_ff;
      l_we    = 1'b0;
      l_waddr = '0;
      l_wdata = tid_ff;
      l_raddr = cur_addr;

      lv       = '0;
      need_add = 1'b0;
      hit      = 1'b0;
      rm_go    = 1'b0;
      rm_lvl   = '0;
      nxt      = PW1'(li_ff) + PW1'(1);
      nn       = rn_ff - CW'(1);
      c        = '0;
      n        = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               tid_in    = tid_ext[TIW-1:0];
               oor_in    = 32'(req_payload.task_id) >= NUM_TASKS;
               lraw_in   = req_payload.level;
               prq_in    = req_payload.priority_req;
               idx_in    = '0;
               r_st_in   = STATUS_OK;
               r_task_in = '0;
               r_jmp_in  = 1'b0;
               r_slc_in  = '0;
               r_slv_in  = 1'b0;
               s_raddr   = (req_payload.func == FUNC_ALLOC) ? '0 : tid_ext[TIW-1:0];
               case (req_payload.func)
                  FUNC_ALLOC: state_in = S_ALLOC;
                  FUNC_RUN:   state_in = S_RUN;
                  FUNC_SLEEP: state_in = S_SLEEP;
                  default:    state_in = S_SWITCH;
               endcase
            end
         end

         S_ALLOC: begin
            if (s_st == SLOT_FREE) begin
               s_we      = 1'b1;
               s_waddr   = idx_ff;
               s_wdata   = {SLOT_ALLOC, s_pr, s_lv};
               r_task_in = idx_ff;
               state_in  = S_OUT;
            end else if (32'(idx_ff) == NUM_TASKS - 1) begin
               r_st_in  = STATUS_NO_FREE;
               state_in = S_OUT;
            end else begin
               idx_in  = idx_ff + TIW'(1);
               s_raddr = idx_ff + TIW'(1);
            end
         end

         S_RUN: begin
            if (lraw_ff[3]) begin
               lv = s_lv;
            end else if (32'(lraw_ff) >= NUM_LEVELS) begin
               lv = LW'(NUM_LEVELS - 1);
            end else begin
               lv = LW'(lraw_ff[2:0]);
            end
            need_add = s_st != SLOT_ACTIVE || s_lv != lv;
            if (oor_ff) begin
               state_in = S_CUR_RD;
            end else if (need_add && cnt_ff[lv] >= CW'(PER_LEVEL)) begin
               r_st_in  = STATUS_LIST_FULL;
               state_in = S_CUR_RD;
            end else begin
               mark_in = 1'b1;
               npr_in  = (prq_ff != '0) ? prq_ff : s_pr;
               lv_in   = lv;
               if (s_st == SLOT_ACTIVE && s_lv != lv) begin
                  rm_go        = 1'b1;
                  rm_lvl       = s_lv;
                  ret_sleep_in = 1'b0;
               end else if (s_st != SLOT_ACTIVE) begin
                  state_in = S_ADD;
               end else begin
                  s_we     = 1'b1;
                  s_wdata  = {SLOT_ACTIVE, npr_in, s_lv};
                  state_in = S_CUR_RD;
               end
            end
         end

         S_SLEEP: begin
            hit = srv_ok && l_data == tid_ff;
            if (oor_ff || s_st != SLOT_ACTIVE) begin
               state_in = S_CUR_RD;
            end else if (hit && tot_ff <= TOTW'(1)) begin
               r_st_in  = STATUS_NO_OTHER;
               state_in = S_CUR_RD;
            end else begin
               s_we         = 1'b1;
               s_wdata      = {SLOT_ALLOC, s_pr, s_lv};
               curhit_in    = hit;
               rm_go        = 1'b1;
               rm_lvl       = s_lv;
               ret_sleep_in = 1'b1;
            end
         end

         S_RM_SRCH: begin
            if (l_data == tid_ff) begin
               pos_in = li_ff;
               if (nxt < PW1'(rn_ff)) begin
                  li_in    = nxt[PW-1:0];
                  l_raddr  = lst_addr(rlv_ff, nxt[PW-1:0]);
                  state_in = S_RM_CMP;
               end else begin
                  state_in = S_RM_FIN;
               end
            end else if (nxt < PW1'(rn_ff)) begin
               li_in   = nxt[PW-1:0];
               l_raddr = lst_addr(rlv_ff, nxt[PW-1:0]);
            end else begin
               // not linked: leave counts alone
               state_in = ret_sleep_ff ? S_SLEEP_END : S_ADD;
            end
         end

         S_RM_CMP: begin
            // shift one entry down while the next one is fetched
            l_we    = 1'b1;
            l_waddr = lst_addr(rlv_ff, li_ff - PW'(1));
            l_wdata = l_data;
            if (nxt < PW1'(rn_ff)) begin
               li_in   = nxt[PW-1:0];
               l_raddr = lst_addr(rlv_ff, nxt[PW-1:0]);
            end else begin
               state_in = S_RM_FIN;
            end
         end

         S_RM_FIN: begin
            cnt_in[rlv_ff] = nn;
            c = cur_ff[rlv_ff];
            if (pos_ff < c) begin
               c = c - PW'(1);
            end
            if (CW'(c) >= nn) begin
               c = '0;
            end
            cur_in[rlv_ff] = c;
            tot_in   = tot_ff - TOTW'(1);
            state_in = ret_sleep_ff ? S_SLEEP_END : S_ADD;
         end

         S_ADD: begin
            n = cnt_ff[lv_ff];
            if (n < CW'(PER_LEVEL)) begin
               l_we          = 1'b1;
               l_waddr       = lst_addr(lv_ff, PW'(n));
               l_wdata       = tid_ff;
               cnt_in[lv_ff] = n + CW'(1);
               tot_in        = tot_ff + TOTW'(1);
            end
            s_we     = 1'b1;
            s_wdata  = {SLOT_ACTIVE, npr_ff, lv_ff};
            state_in = S_CUR_RD;
         end

         S_SLEEP_END: begin
            if (curhit_ff) begin
               srv_in   = rs_lvl;
               mark_in  = 1'b0;
               r_jmp_in = 1'b1;
            end
            state_in = S_CUR_RD;
         end

         S_SWITCH: begin
            old_in   = l_data;
            oldok_in = srv_ok;
            if (srv_ok) begin
               n = cnt_ff[srv_idx];
               c = cur_ff[srv_idx];
               if (n == '0 || PW1'(c) + PW1'(1) >= PW1'(n)) begin
                  cur_in[srv_idx] = '0;
               end else begin
                  cur_in[srv_idx] = c + PW'(1);
               end
            end
            if (mark_ff) begin
               srv_in  = rs_lvl;
               mark_in = 1'b0;
            end
            state_in = S_SW_RD;
         end

         S_SW_RD: begin
            state_in = S_SW_NEW;
         end

         S_SW_NEW: begin
            if (!srv_ok) begin
               r_st_in  = STATUS_NO_OTHER;
               state_in = S_OUT;
            end else begin
               r_task_in = l_data;
               s_raddr   = l_data;
               state_in  = S_SW_SLICE;
            end
         end

         S_SW_SLICE: begin
            r_slc_in = s_pr;
            r_slv_in = 1'b1;
            r_jmp_in = !oldok_ff || r_task_ff != old_ff;
            state_in = S_OUT;
         end

         S_CUR_RD: begin
            state_in = S_CUR_DN;
         end

         S_CUR_DN: begin
            r_task_in = srv_ok ? l_data : '0;
            state_in  = S_OUT;
         end

         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = r_st_ff;
               rsp_in.result_task   = task_ext[5:0];
               rsp_in.jump          = r_jmp_ff;
               rsp_in.slice_ticks   = r_slc_ff;
               rsp_in.slice_valid   = r_slv_ff;
               rsp_in.current_level = lvl_ext[3:0];
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rm_go) begin
         rlv_in = rm_lvl;
         rn_in  = cnt_ff[rm_lvl];
         li_in  = '0;
         if (cnt_ff[rm_lvl] == '0) begin
            state_in = ret_sleep_in ? S_SLEEP_END : S_ADD;
         end else begin
            l_raddr  = lst_addr(rm_lvl, '0);
            state_in = S_RM_SRCH;
         end
      end
   end

   assign task_ext = {6'b0, r_task_ff};
   assign lvl_ext  = {4'b0, srv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         srv_ff       <= '0;
         mark_ff      <= 1'b1;
         tot_ff       <= TOTW'(2);
         vld_ff       <= '0;
         w0_ff        <= 1'b0;
         w1_ff        <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            cnt_ff[i] <= (i == 0 || i == NUM_LEVELS - 1) ? CW'(1) : '0;
            cur_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         srv_ff       <= srv_in;
         mark_ff      <= mark_in;
         tot_ff       <= tot_in;
         cnt_ff       <= cnt_in;
         cur_ff       <= cur_in;
         if (s_we) begin
            vld_ff[s_waddr] <= 1'b1;
         end
         if (l_we && l_waddr == AW'(0)) begin
            w0_ff <= 1'b1;
         end
         if (l_we && l_waddr == L1ADDR) begin
            w1_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tid_ff       <= tid_in;
      oor_ff       <= oor_in;
      lraw_ff      <= lraw_in;
      prq_ff       <= prq_in;
      npr_ff       <= npr_in;
      lv_ff        <= lv_in;
      idx_ff       <= idx_in;
      li_ff        <= li_in;
      rlv_ff       <= rlv_in;
      rn_ff        <= rn_in;
      pos_ff       <= pos_in;
      ret_sleep_ff <= ret_sleep_in;
      curhit_ff    <= curhit_in;
      old_ff       <= old_in;
      oldok_ff     <= oldok_in;
      r_st_ff      <= r_st_in;
      r_task_ff    <= r_task_in;
      r_jmp_ff     <= r_jmp_in;
      r_slc_ff     <= r_slc_in;
      r_slv_ff     <= r_slv_in;
      rsp_ff       <= rsp_in;
      sq_ff        <= s_raddr;
      lq_ff        <= l_raddr;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### dv/multilevel_round_robin_scheduler_tb.sv
module multilevel_round_robin_scheduler_tb;
   import mrrs_pkg::*;

   localparam int NTASK   = 64;
   localparam int NLEVEL  = 8;
   localparam int PERLVL  = 64;
   localparam int WD_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   multilevel_round_robin_scheduler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #6 clock = ~clock;

   // scheduler shadow state
   logic [1:0] sh_state [NTASK];
   logic [7:0] sh_prio  [NTASK];
   logic [2:0] sh_level [NTASK];
   logic [5:0] sh_list  [NLEVEL][PERLVL];
   int         sh_count [NLEVEL];
   int         sh_cursor[NLEVEL];
   int         sh_serving;
   bit         sh_mark;

   rsp_type pending_rsp[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      hold_rsp = 1'b0;
   bit      stall_mode = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void shadow_reset();
      for (int i = 0; i < NTASK; i++) begin
         sh_state[i] = SLOT_FREE; sh_prio[i] = '0; sh_level[i] = '0;
      end
      for (int l = 0; l < NLEVEL; l++) begin
         sh_count[l] = 0; sh_cursor[l] = 0;
         for (int j = 0; j < PERLVL; j++) sh_list[l][j] = '0;
      end
      sh_state[0] = SLOT_ACTIVE; sh_prio[0] = 8'd2;
      sh_list[0][0] = 6'd0; sh_count[0] = 1;
      sh_state[1] = SLOT_ACTIVE; sh_prio[1] = 8'd1; sh_level[1] = 3'(NLEVEL - 1);
      sh_list[NLEVEL-1][0] = 6'd1; sh_count[NLEVEL-1] = 1;
      sh_serving = 0; sh_mark = 1'b1;
   endfunction

   function automatic bit running_task(output int t);
      t = 0;
      if (sh_serving >= NLEVEL) return 1'b0;
      t = sh_list[sh_serving][sh_cursor[sh_serving]];
      return 1'b1;
   endfunction

   function automatic void pick_level();
      int i;
      for (i = 0; i < NLEVEL; i++) if (sh_count[i] > 0) break;
      sh_serving = i; sh_mark = 1'b0;
   endfunction

   function automatic void unlink_task(input int t);
      int lv, n, i;
      lv = sh_level[t]; n = sh_count[lv];
      sh_state[t] = SLOT_ALLOC;
      for (i = 0; i < n; i++) if (sh_list[lv][i] == t) break;
      if (i >= n) return;
      n--; sh_count[lv] = n;
      if (i < sh_cursor[lv]) sh_cursor[lv]--;
      if (sh_cursor[lv] >= n) sh_cursor[lv] = 0;
      for (; i < n; i++) sh_list[lv][i] = sh_list[lv][i+1];
   endfunction

   function automatic rsp_type schedule_step(input req_type r);
      rsp_type o;
      int cur, lv, tot, old, nw, n, c;
      bit ok, old_ok, need;
      o = '0; cur = 0;
      case (r.func)
         FUNC_ALLOC: begin
            o.status = STATUS_NO_FREE;
            for (int i = 0; i < NTASK; i++)
               if (sh_state[i] == SLOT_FREE) begin
                  sh_state[i] = SLOT_ALLOC; o.result_task = 6'(i); o.status = STATUS_OK;
                  break;
               end
         end
         FUNC_RUN: begin
            lv = (r.level < 0) ? int'(sh_level[r.task_id]) : int'(r.level);
            need = sh_state[r.task_id] != SLOT_ACTIVE || sh_level[r.task_id] != lv;
            if (need && sh_count[lv] >= PERLVL) o.status = STATUS_LIST_FULL;
            else begin
               if (r.priority_req != 0) sh_prio[r.task_id] = r.priority_req;
               if (sh_state[r.task_id] == SLOT_ACTIVE && sh_level[r.task_id] != lv)
                  unlink_task(r.task_id);
               if (sh_state[r.task_id] != SLOT_ACTIVE) begin
                  sh_level[r.task_id] = 3'(lv);
                  if (sh_count[lv] < PERLVL) begin
                     sh_list[lv][sh_count[lv]] = r.task_id; sh_count[lv]++;
                  end
                  sh_state[r.task_id] = SLOT_ACTIVE;
               end
               sh_mark = 1'b1;
            end
            void'(running_task(cur)); o.result_task = 6'(cur);
         end
         FUNC_SLEEP: begin
            if (sh_state[r.task_id] == SLOT_ACTIVE) begin
               tot = 0;
               ok = running_task(cur);
               for (int i = 0; i < NLEVEL; i++) tot += sh_count[i];
               if (ok && cur == r.task_id && tot <= 1) o.status = STATUS_NO_OTHER;
               else begin
                  unlink_task(r.task_id);
                  if (ok && cur == r.task_id) begin
                     pick_level(); o.jump = 1'b1;
                  end
               end
            end
            void'(running_task(cur)); o.result_task = 6'(cur);
         end
         default: begin
            old_ok = running_task(old);
            if (old_ok) begin
               n = sh_count[sh_serving]; c = sh_cursor[sh_serving];
               if (n == 0) c = 0;
               else begin
                  c++; if (c >= n) c = 0;
               end
               sh_cursor[sh_serving] = c;
            end
            if (sh_mark) pick_level();
            if (!running_task(nw)) o.status = STATUS_NO_OTHER;
            else begin
               o.result_task = 6'(nw); o.slice_ticks = sh_prio[nw]; o.slice_valid = 1'b1;
               o.jump = (!old_ok || nw != old);
            end
         end
      endcase
      o.current_level = 4'(sh_serving);
      return o;
   endfunction

   // sender: one transfer; valid stays up until a gap or a drain drops it
   task automatic send_item(input req_type r);
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(schedule_step(r));
   endtask

   task automatic send_op(input logic [1:0] f, input int t, input int lv, input int p);
      req_type r;
      r.func = f; r.task_id = 6'(t); r.level = 4'(lv); r.priority_req = 8'(p);
      send_item(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (stall_mode) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WD_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) report_mismatch("unexpected result", 1, 0);
            else begin
               want = pending_rsp.pop_front();
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", rsp_payload.status, want.status);
               if (rsp_payload.result_task !== want.result_task)
                  report_mismatch("result_task", rsp_payload.result_task, want.result_task);
               if (rsp_payload.jump !== want.jump)
                  report_mismatch("jump", rsp_payload.jump, want.jump);
               if (rsp_payload.slice_ticks !== want.slice_ticks)
                  report_mismatch("slice_ticks", rsp_payload.slice_ticks, want.slice_ticks);
               if (rsp_payload.slice_valid !== want.slice_valid)
                  report_mismatch("slice_valid", rsp_payload.slice_valid, want.slice_valid);
               if (rsp_payload.current_level !== want.current_level)
                  report_mismatch("current_level", rsp_payload.current_level,
                                  want.current_level);
            end
         end
      end
   end

   task automatic test_directed();
      send_op(FUNC_SWITCH, 0, 0, 0);
      send_op(FUNC_SWITCH, 0, 0, 0);
      send_op(FUNC_ALLOC, 0, 0, 0);
      send_op(FUNC_RUN, 2, 3, 255);
      send_op(FUNC_RUN, 2, -1, 0);
      send_op(FUNC_RUN, 2, 7, 0);
      send_op(FUNC_RUN, 5, 0, 9);
      send_op(FUNC_RUN, 63, -1, 1);
      send_op(FUNC_SLEEP, 40, 0, 0);
      send_op(FUNC_SWITCH, 0, 0, 0);
      send_op(FUNC_SLEEP, 5, 0, 0);
      send_op(FUNC_SLEEP, 0, 0, 0);
      send_op(FUNC_SWITCH, 0, 0, 0);
      send_op(FUNC_SLEEP, 2, 0, 0);
      send_op(FUNC_SLEEP, 63, 0, 0);
      send_op(FUNC_SWITCH, 0, 0, 0);
      send_op(FUNC_SLEEP, 1, 0, 0);
      send_op(FUNC_SWITCH, 0, 0, 0);
      send_op(FUNC_RUN, 0, 0, 0);
      send_op(FUNC_SWITCH, 0, 0, 0);
      drain();
   endtask

   // exhaust free slots, then fill one level list to the brim
   task automatic test_full();
      for (int i = 0; i < 66; i++) send_op(FUNC_ALLOC, 0, 0, 0);
      for (int i = 0; i < NTASK; i++) send_op(FUNC_RUN, i, 4, $urandom_range(0, 255));
      send_op(FUNC_RUN, 0, 5, 3);
      send_op(FUNC_RUN, 1, 4, 3);
      for (int i = 0; i < 8; i++) send_op(FUNC_SWITCH, 0, 0, 0);
      for (int i = 0; i < NTASK; i += 2) send_op(FUNC_SLEEP, i, 0, 0);
      drain();
   endtask

   task automatic test_random(input int count);
      req_type r;
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && count > 0) begin
            r = req_type'($urandom);
            r.level = 4'($urandom_range(0, 8) - 1);
            if ($urandom_range(0, 1)) r.task_id = 6'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
               0, 1:       r.func = FUNC_SWITCH;
               2, 3, 4:    r.func = FUNC_RUN;
               5, 6:       r.func = FUNC_SLEEP;
               7:          r.func = FUNC_ALLOC;
               default:    r.func = 2'($urandom);
            endcase
            send_item(r);
            burst--; count--;
         end
         if ($urandom_range(0, 1)) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         test_random(40);
      join
      drain();
   endtask

   initial begin
      shadow_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      stall_mode = 1'b1;
      test_full();
      test_backpressure();
      stall_mode = 1'b0;
      test_random(500);
      drain();
      stall_mode = 1'b1;
      test_random(1100);
      drain();
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

### sim.f
design/mrrs_pkg.sv
design/mrrs_ram.sv
design/multilevel_round_robin_scheduler.sv
dv/multilevel_round_robin_scheduler_tb.sv
